@@ src/kea_pkg.sv @@
`default_nettype none

package kea_pkg;

    localparam int KeyCodeW = 6;
    localparam int CharW    = 7;
    localparam int KindW    = 3;
    localparam int TblDepth = 1 << KeyCodeW;

    // Modifier kinds carried with a modifier event.
    localparam logic [KindW-1:0] MOD_NONE  = 3'd0;
    localparam logic [KindW-1:0] MOD_SHIFT = 3'd1;
    localparam logic [KindW-1:0] MOD_CTRL  = 3'd2;
    localparam logic [KindW-1:0] MOD_ALT   = 3'd3;
    localparam logic [KindW-1:0] MOD_WIN   = 3'd4;
    localparam logic [KindW-1:0] MOD_CAPS  = 3'd5;

    // Event types on the tuser line.
    localparam logic REQ_KEY = 1'b0;
    localparam logic REQ_MOD = 1'b1;

    localparam logic [CharW-1:0] CTRL_MASK = 7'h1F;

    localparam logic [CharW-1:0] PLAIN_TBL [TblDepth] = '{
        7'd27,  7'd49,  7'd50,  7'd51,  7'd52,  7'd53,  7'd54,  7'd55,
        7'd56,  7'd57,  7'd48,  7'd45,  7'd61,  7'd127, 7'd9,   7'd113,
        7'd119, 7'd101, 7'd114, 7'd116, 7'd121, 7'd117, 7'd105, 7'd111,
        7'd112, 7'd91,  7'd93,  7'd92,  7'd97,  7'd115, 7'd100, 7'd102,
        7'd103, 7'd104, 7'd106, 7'd107, 7'd108, 7'd59,  7'd39,  7'd10,
        7'd122, 7'd120, 7'd99,  7'd118, 7'd98,  7'd110, 7'd109, 7'd44,
        7'd46,  7'd47,  7'd32,  7'd96,  7'd16,  7'd14,  7'd8,   7'd32,
        7'd127, 7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0
    };

    localparam logic [CharW-1:0] UPPER_TBL [TblDepth] = '{
        7'd27,  7'd33,  7'd64,  7'd35,  7'd36,  7'd37,  7'd94,  7'd38,
        7'd42,  7'd40,  7'd41,  7'd95,  7'd43,  7'd127, 7'd9,   7'd81,
        7'd87,  7'd69,  7'd82,  7'd84,  7'd89,  7'd85,  7'd73,  7'd79,
        7'd80,  7'd123, 7'd125, 7'd124, 7'd65,  7'd83,  7'd68,  7'd70,
        7'd71,  7'd72,  7'd74,  7'd75,  7'd76,  7'd58,  7'd34,  7'd10,
        7'd90,  7'd88,  7'd67,  7'd86,  7'd66,  7'd78,  7'd77,  7'd60,
        7'd62,  7'd63,  7'd32,  7'd126, 7'd2,   7'd6,   7'd127, 7'd32,
        7'd127, 7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0
    };

    typedef struct packed {
        logic [CharW-1:0] upper;
        logic [CharW-1:0] plain;
    } tbl_entry_t;

    function automatic logic is_lower(input logic [CharW-1:0] c);
        return (c >= 7'd97) && (c <= 7'd122);
    endfunction

    function automatic logic is_upper(input logic [CharW-1:0] c);
        return (c >= 7'd65) && (c <= 7'd90);
    endfunction

endpackage

`default_nettype wire

@@ src/keyboard_event_to_ascii.sv @@
`default_nettype none

// Keyboard event translator. Each input word is one event: tuser says whether it is an
// ordinary key event or a modifier event, and tdata carries the press flag, the modifier
// kind and the key code. Shift and ctrl follow their press and release, a caps lock press
// toggles caps lock, and a key press produces one character word on the output unless the
// key has no translation. Releases and modifier events produce nothing. One word is taken
// every clock cycle while the output is not held up. Accepting an event registers the translation
// table read; the character is then loaded into the output register as the event leaves the
// table stage. A held output stalls the input only when the event in the table stage has a
// character to emit.
module keyboard_event_to_ascii
    import kea_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,  // pressed[0], modifier_kind[3:1], key_code[9:4], zero
    input  wire logic        s_tuser,  // req_type[0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata   // character[6:0], zero
);

    logic                s1_valid_reg;
    logic                s1_valid_next;
    logic                s1_req_type_reg;
    logic                s1_pressed_reg;
    logic [KindW-1:0]    s1_kind_reg;
    tbl_entry_t          tbl_q_reg;

    logic                shift_reg;
    logic                ctrl_reg;
    logic                caps_reg;
    logic                shift_next;
    logic                ctrl_next;
    logic                caps_next;

    logic                out_valid_reg;
    logic                out_valid_next;
    logic [CharW-1:0]    char_reg;

    logic                accept;
    logic                s1_move;
    logic                s1_emit;
    logic                use_upper;
    logic [CharW-1:0]    sel_char;
    logic [CharW-1:0]    res_char;
    logic [KeyCodeW-1:0] in_key_code;

    assign in_key_code = s_tdata[9:4];
    assign accept      = s_tvalid && s_tready;

    // Translation table read: both entries for the key come back together, registered when the event is accepted.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tbl_q_reg.plain <= PLAIN_TBL[in_key_code];
            tbl_q_reg.upper <= UPPER_TBL[in_key_code];
            s1_req_type_reg <= s_tuser;
            s1_pressed_reg  <= s_tdata[0];
            s1_kind_reg     <= s_tdata[3:1];
        end
    end

    // The modifier flags are updated as events leave the table stage, so a key event
    // always sees every earlier event already applied.
    always_comb
    begin
        use_upper = shift_reg ^ (caps_reg && is_lower(tbl_q_reg.plain));
        sel_char  = use_upper ? tbl_q_reg.upper : tbl_q_reg.plain;
        if (ctrl_reg && (is_lower(sel_char) || is_upper(sel_char)))
        begin
            res_char = sel_char & CTRL_MASK;
        end
        else
        begin
            res_char = sel_char;
        end
    end

    assign s1_emit  = s1_valid_reg && (s1_req_type_reg == REQ_KEY) && s1_pressed_reg
                      && (res_char != '0);
    assign s1_move  = s1_valid_reg && (!s1_emit || !out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_move;

    always_comb
    begin
        shift_next = shift_reg;
        ctrl_next  = ctrl_reg;
        caps_next  = caps_reg;
        if (s1_move && (s1_req_type_reg == REQ_MOD))
        begin
            unique case (s1_kind_reg)
                MOD_SHIFT: shift_next = s1_pressed_reg;
                MOD_CTRL:  ctrl_next  = s1_pressed_reg;
                MOD_CAPS:  caps_next  = caps_reg ^ s1_pressed_reg;
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_comb
    begin
        if (s1_move && s1_emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            shift_reg     <= 1'b0;
            ctrl_reg      <= 1'b0;
            caps_reg      <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            shift_reg     <= shift_next;
            ctrl_reg      <= ctrl_next;
            caps_reg      <= caps_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move && s1_emit)
        begin
            char_reg <= res_char;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, char_reg};

    // A word on the output never carries the null character.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (char_reg != '0))
        else $error("null character presented on the output");

    // A caps lock press leaving the table stage flips the caps lock state.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_move && (s1_req_type_reg == REQ_MOD) && s1_pressed_reg
         && (s1_kind_reg == MOD_CAPS)) |=> (caps_reg != $past(caps_reg)))
        else $error("caps lock press did not toggle caps lock");

    // Key events leave all modifier flags alone.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_move && (s1_req_type_reg == REQ_KEY))
        |=> ($stable(shift_reg) && $stable(ctrl_reg) && $stable(caps_reg)))
        else $error("key event changed a modifier flag");

    // Modifier events never produce a character.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && (s1_req_type_reg == REQ_MOD)) |-> !s1_emit)
        else $error("modifier event produced a character");

endmodule

`default_nettype wire
